/* hw/rtl/speck_pkg.sv */
package speck_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned ROUNDS = 32;
  localparam int unsigned RndW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 2'd1;

  localparam int unsigned RorAmt = 8;
  localparam int unsigned RolAmt = 3;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } blk_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t k;
    word_t l;
  } stage_t;

  function automatic word_t ror_f(word_t v);
    return (v >> RorAmt) | (v << (WordW - RorAmt));
  endfunction

  function automatic word_t rol_f(word_t v);
    return (v << RolAmt) | (v >> (WordW - RolAmt));
  endfunction

  // One cipher round together with the matching key-schedule step.
  function automatic stage_t round_f(stage_t s, logic [RndW-1:0] rnd);
    stage_t r;
    r.x = (ror_f(s.x) + s.y) ^ s.k;
    r.y = rol_f(s.y) ^ r.x;
    r.l = (ror_f(s.l) + s.k) ^ WordW'(rnd);
    r.k = rol_f(s.k) ^ r.l;
    return r;
  endfunction

endpackage

/* hw/rtl/speck_in_if.sv */
interface speck_in_if
  import speck_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t plain_x;
  word_t plain_y;

  modport source (output valid, output plain_x, output plain_y, input ready);
  modport sink (input valid, input plain_x, input plain_y, output ready);
endinterface

/* hw/rtl/speck_out_if.sv */
interface speck_out_if
  import speck_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t cipher_x;
  word_t cipher_y;

  modport source (output valid, output cipher_x, output cipher_y, input ready);
  modport sink (input valid, input cipher_x, input cipher_y, output ready);
endinterface

/* hw/rtl/speck_round.sv */
module speck_round
  import speck_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [RndW-1:0] rnd_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  stage_t          in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output stage_t          out_data_o
);

  logic   valid_q;
  stage_t data_q;
  stage_t data_d;

  // The stage takes a new item when it is empty or its item moves on.
  assign in_ready_o = !valid_q || out_ready_i;
  assign data_d = round_f(in_data_i, rnd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o = data_q;

endmodule

/* hw/rtl/speck_skid.sv */
module speck_skid
  import speck_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  blk_t   in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output blk_t   out_data_o
);

  logic valid_q;
  logic skid_q;
  blk_t data_q;
  blk_t skid_data_q;
  logic main_free;

  // Ready depends only on the skid register, so the output handshake never
  // reaches the ready chain of the round stages combinationally.
  assign in_ready_o = !skid_q;
  assign main_free = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      skid_q <= 1'b0;
    end else if (main_free) begin
      if (skid_q) begin
        valid_q <= 1'b1;
        skid_q <= 1'b0;
      end else begin
        valid_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_q) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      if (skid_q) begin
        data_q <= skid_data_q;
      end else if (in_valid_i) begin
        data_q <= in_data_i;
      end
    end else if (in_valid_i && !skid_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o = data_q;

endmodule

/* hw/rtl/speck_block_encrypt.sv */
// Channel   Direction  Payload               Transfer when
// in_i      sink       plain_x, plain_y      in_i.valid && in_i.ready
// out_o     source     cipher_x, cipher_y    out_o.valid && out_o.ready
// cfg       write      cfg_idx_i, cfg_data_i cfg_we_i
//
// One round stage per round, each holding a 64-bit add and XORs on both the
// data and the key schedule, then an output register with a skid entry.
// A block passes through every round stage register and then the output
// register. One block may be transferred in every cycle while the output
// is not stalled. Reset clears the valid bits and both key words. A stall
// at the output fills the empty stages first and then holds every stage.
module speck_block_encrypt
  import speck_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  word_t              cfg_data_i,
  speck_in_if.sink           in_i,
  speck_out_if.source        out_o
);

  word_t key_low_q;
  word_t key_high_q;

  logic   st_vld [ROUNDS+1];
  logic   st_rdy [ROUNDS+1];
  stage_t st_dat [ROUNDS+1];

  blk_t res_in;
  blk_t res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LOW:  key_low_q <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign st_vld[0] = in_i.valid;
  assign in_i.ready = st_rdy[0];
  assign st_dat[0] = '{x: in_i.plain_x, y: in_i.plain_y, k: key_low_q, l: key_high_q};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    speck_round u_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rnd_i       (RndW'(g)),
      .in_valid_i  (st_vld[g]),
      .in_ready_o  (st_rdy[g]),
      .in_data_i   (st_dat[g]),
      .out_valid_o (st_vld[g+1]),
      .out_ready_i (st_rdy[g+1]),
      .out_data_o  (st_dat[g+1])
    );
  end

  assign res_in = '{x: st_dat[ROUNDS].x, y: st_dat[ROUNDS].y};

  speck_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_vld[ROUNDS]),
    .in_ready_o  (st_rdy[ROUNDS]),
    .in_data_i   (res_in),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res_out)
  );

  assign out_o.cipher_x = res_out.x;
  assign out_o.cipher_y = res_out.y;

`ifndef SYNTH
  // An accepted block always occupies the first round stage next cycle.
  a_first_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> st_vld[1])
    else $error("accepted block missing from first round stage");

  // The skid entry is only in use while the output register holds a result.
  a_skid_behind_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_rdy[ROUNDS] |-> out_o.valid)
    else $error("skid entry full while output register empty");

  // A block in the last round stage that cannot move on stays put.
  a_last_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_vld[ROUNDS] && !st_rdy[ROUNDS] |=> st_vld[ROUNDS])
    else $error("block dropped from last round stage under stall");
`endif

endmodule
